FILE: design/wgch_pkg.sv
// Shared types, codes and constants for the windowed GC percent histogram core.
`timescale 1ns / 1ps
`default_nettype none

package wgch_pkg;

  // histogram geometry and result limits
  localparam int HIST_BINS = 101;
  localparam int BIN_W     = 7;
  localparam int COUNT_W   = 32;
  localparam int PCT_MAX   = 100;
  localparam int WS_W      = 8;
  localparam int DIV_STEPS = 8;
  localparam int NUM_W     = 16;

  // configuration register indexes
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_REGION_MASK = 1'b1;

  // result kinds
  localparam logic KIND_PERCENT = 1'b0;
  localparam logic KIND_COUNT   = 1'b1;

  typedef enum logic [1:0] {
    MODE_BASE  = 2'd0,
    MODE_PAD   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_GC    = 2'd1,
    CLS_AT    = 2'd2
  } class_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic slide;
    logic load_count;
    logic load_zero;
    logic div_init;
    logic div_step;
    logic finish;
    logic hist_rd;
    logic hist_wr;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  filling;
    logic  early;
    logic  div_last;
  } stat_t;

  // case-insensitive base classing
  function automatic class_t classify(input logic [7:0] ch);
    logic [7:0] up;
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) up = ch - 8'd32;
    if (up == 8'h47 || up == 8'h43) return CLS_GC;
    if (up == 8'h41 || up == 8'h54) return CLS_AT;
    return CLS_OTHER;
  endfunction

endpackage

`default_nettype wire

FILE: design/wgch_ctrl.sv
// Sequencing state machine and handshake control for the GC histogram core.
`timescale 1ns / 1ps
`default_nettype none

module wgch_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire wgch_pkg::stat_t stat,
  output wgch_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN,
    ST_HRD,
    ST_HWR,
    ST_EMIT
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.mode)
          wgch_pkg::MODE_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
          wgch_pkg::MODE_READ: begin
            cmd.load_count = 1'b1;
            state_next     = ST_EMIT;
          end
          wgch_pkg::MODE_PAD: begin
            cmd.load_zero = 1'b1;
            state_next    = ST_HRD;
          end
          wgch_pkg::MODE_BASE: begin
            cmd.slide = 1'b1;
            priority if (!stat.filling) begin
              state_next = ST_DIV_INIT;
            end else if (stat.early) begin
              cmd.load_zero = 1'b1;
              state_next    = ST_HRD;
            end else begin
              state_next = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_HRD;
      end
      ST_HRD: begin
        cmd.hist_rd = 1'b1;
        state_next  = ST_HWR;
      end
      ST_HWR: begin
        cmd.hist_wr = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        // output register free or draining this cycle
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // state and output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/wgch_dp.sv
// Datapath: class delay line, window counts, iterative divider, histogram store.
`timescale 1ns / 1ps
`default_nettype none

module wgch_dp #(
  parameter int MAX_WINDOW = 255
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [wgch_pkg::WS_W-1:0]    cfg_data,
  input  wire logic [1:0]                   mode,
  input  wire logic [7:0]                   base,
  input  wire logic                         in_region,
  input  wire logic [wgch_pkg::BIN_W-1:0]   bin_index,
  input  wire wgch_pkg::cmd_t               cmd,
  output wgch_pkg::stat_t                   stat,
  output logic                              kind,
  output logic [wgch_pkg::BIN_W-1:0]        gc_percent,
  output logic [wgch_pkg::COUNT_W-1:0]      bin_count
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int WS_W  = wgch_pkg::WS_W;
  localparam int BIN_W = wgch_pkg::BIN_W;
  localparam int CNT_W = wgch_pkg::COUNT_W;
  localparam int NUM_W = wgch_pkg::NUM_W;

  // configuration
  logic [WS_W-1:0] window_size;
  logic            region_mask_enable;
  logic [WS_W-1:0] ws;

  // window state
  logic [PTR_W-1:0] wp;
  logic [WS_W-1:0]  gc_cnt, at_cnt, bases_seen;

  // latched item
  wgch_pkg::mode_t  item_mode;
  wgch_pkg::class_t item_cls;
  logic             item_region;
  logic             item_oor;

  // delay line memory
  wgch_pkg::class_t line_mem [MAX_WINDOW];
  wgch_pkg::class_t old_cls;
  logic [WS_W:0]    old_addr9;
  logic [PTR_W-1:0] old_addr;

  // histogram store with per-bin valid bits
  logic [CNT_W-1:0] hist [wgch_pkg::HIST_BINS];
  logic [wgch_pkg::HIST_BINS-1:0] hist_vld;
  logic [CNT_W-1:0] hist_rdata;
  logic             hist_rvld;
  logic [BIN_W-1:0] hist_bin, hist_raddr, bin_safe;
  logic [CNT_W-1:0] hist_cur;

  // divider
  logic [NUM_W-1:0] div_rem, div_den;
  logic [7:0]       div_q;
  logic [2:0]       div_cnt;
  logic             win_bad;
  logic             q_bit;

  // staged result
  logic             res_kind;
  logic [BIN_W-1:0] res_pct;
  logic [CNT_W-1:0] res_count;
  logic [BIN_W-1:0] pct_fin;

  logic             filling;
  logic             gc_in, at_in, gc_out, at_out;

  // effective window size
  always_comb begin
    if (window_size == '0) begin
      ws = WS_W'(1);
    end else if (window_size > WS_W'(MAX_WINDOW)) begin
      ws = WS_W'(MAX_WINDOW);
    end else begin
      ws = window_size;
    end
  end

  // address of the class leaving the window
  always_comb begin
    if ({1'b0, (WS_W)'(wp)} >= {1'b0, ws}) begin
      old_addr9 = {1'b0, (WS_W)'(wp)} - {1'b0, ws};
    end else begin
      old_addr9 = {1'b0, (WS_W)'(wp)} + (WS_W + 1)'(MAX_WINDOW) - {1'b0, ws};
    end
  end
  assign old_addr = old_addr9[PTR_W-1:0];

  assign filling = (bases_seen < ws);
  assign gc_in   = (item_cls == wgch_pkg::CLS_GC);
  assign at_in   = (item_cls == wgch_pkg::CLS_AT);
  assign gc_out  = !filling && (old_cls == wgch_pkg::CLS_GC);
  assign at_out  = !filling && (old_cls == wgch_pkg::CLS_AT);

  assign stat.mode     = item_mode;
  assign stat.filling  = filling;
  assign stat.early    = (bases_seen < {1'b0, ws[WS_W-1:1]});
  assign stat.div_last = (div_cnt == 3'(wgch_pkg::DIV_STEPS - 1));

  // configuration registers and window counts
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size        <= WS_W'(100);
      region_mask_enable <= 1'b0;
      gc_cnt             <= '0;
      at_cnt             <= '0;
      bases_seen         <= '0;
      wp                 <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wgch_pkg::REG_WINDOW_SIZE: begin
            window_size <= cfg_data;
            gc_cnt      <= '0;
            at_cnt      <= '0;
            bases_seen  <= '0;
          end
          wgch_pkg::REG_REGION_MASK: region_mask_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        gc_cnt     <= '0;
        at_cnt     <= '0;
        bases_seen <= '0;
      end
      if (cmd.slide) begin
        gc_cnt <= gc_cnt + WS_W'(gc_in) - WS_W'(gc_out);
        at_cnt <= at_cnt + WS_W'(at_in) - WS_W'(at_out);
        if (filling) bases_seen <= bases_seen + WS_W'(1);
        if (wp == PTR_W'(MAX_WINDOW - 1)) begin
          wp <= '0;
        end else begin
          wp <= wp + PTR_W'(1);
        end
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode   <= wgch_pkg::mode_t'(mode);
      item_cls    <= wgch_pkg::classify(base);
      item_region <= in_region;
      item_oor    <= (bin_index >= BIN_W'(wgch_pkg::HIST_BINS));
    end
  end

  // delay line: read at accept, write on slide
  always_ff @(posedge clk) begin
    if (cmd.accept) old_cls <= line_mem[old_addr];
    if (cmd.slide) line_mem[wp] <= item_cls;
  end

  // divider: (200*gc + ws) / (2*ws), one quotient bit per cycle
  assign q_bit = (div_rem >= div_den);
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_rem <= NUM_W'(gc_cnt) * NUM_W'(200) + NUM_W'(ws);
      div_den <= {ws, 1'b0, 7'b0};
      div_q   <= '0;
      div_cnt <= '0;
      win_bad <= (({1'b0, gc_cnt} + {1'b0, at_cnt}) < {1'b0, ws});
    end else if (cmd.div_step) begin
      if (q_bit) div_rem <= div_rem - div_den;
      div_den <= div_den >> 1;
      div_q   <= {div_q[6:0], q_bit};
      div_cnt <= div_cnt + 3'd1;
    end
  end

  // clamp the percentage; a window with other bases reads zero
  always_comb begin
    if (win_bad) begin
      pct_fin = '0;
    end else if (div_q > 8'(wgch_pkg::PCT_MAX)) begin
      pct_fin = BIN_W'(wgch_pkg::PCT_MAX);
    end else begin
      pct_fin = div_q[BIN_W-1:0];
    end
  end

  // histogram read port
  assign bin_safe   = (bin_index >= BIN_W'(wgch_pkg::HIST_BINS)) ? '0 : bin_index;
  assign hist_raddr = cmd.hist_rd ? hist_bin : bin_safe;
  assign hist_cur   = hist_rvld ? hist_rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.hist_rd) begin
      hist_rdata <= hist[hist_raddr];
      hist_rvld  <= hist_vld[hist_raddr];
    end
    if (cmd.hist_wr) hist[hist_bin] <= hist_cur + CNT_W'(1);
  end

  // bin valid bits: a cleared bin reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      hist_vld <= '0;
    end else if (cmd.hist_wr) begin
      hist_vld[hist_bin] <= 1'b1;
    end
  end

  // staged result and bin to count
  always_ff @(posedge clk) begin
    if (cmd.load_count) begin
      res_kind  <= wgch_pkg::KIND_COUNT;
      res_pct   <= '0;
      res_count <= item_oor ? '0 : hist_cur;
    end
    if (cmd.load_zero) begin
      res_kind  <= wgch_pkg::KIND_PERCENT;
      res_pct   <= '0;
      res_count <= '0;
      hist_bin  <= '0;
    end
    if (cmd.finish) begin
      res_kind  <= wgch_pkg::KIND_PERCENT;
      res_pct   <= pct_fin;
      res_count <= '0;
      hist_bin  <= (region_mask_enable && !item_region) ? '0 : pct_fin;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind       <= res_kind;
      gc_percent <= res_pct;
      bin_count  <= res_count;
    end
  end

endmodule

`default_nettype wire

FILE: design/windowed_gc_percent_histogram_core.sv
// Sequence: a sliding-window base is decoded, run through the iterative divider, finished,
// then counted by a bin read and write before the output step; a pad or first-half filling
// base goes straight to the bin update, a bin read straight to the output step. Restarts
// and silent filling bases give no result. No beat is taken while one is in progress; a
// stalled output holds the next result back in its last step, and the next input beat.
// Reset: synchronous; counts and bin valid bits clear at once, window size 100, mask off.
`timescale 1ns / 1ps
`default_nettype none

module windowed_gc_percent_histogram_core #(
  parameter int MAX_WINDOW = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [wgch_pkg::WS_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  mode,
  input  wire logic [7:0]                  base,
  input  wire logic                        in_region,
  input  wire logic [wgch_pkg::BIN_W-1:0]  bin_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             kind,
  output logic [wgch_pkg::BIN_W-1:0]       gc_percent,
  output logic [wgch_pkg::COUNT_W-1:0]     bin_count
);

  wgch_pkg::cmd_t  cmd;
  wgch_pkg::stat_t stat;

  // sequencing
  wgch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // window, divider and histogram
  wgch_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .base       (base),
    .in_region  (in_region),
    .bin_index  (bin_index),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .gc_percent (gc_percent),
    .bin_count  (bin_count)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the windowed GC percent histogram core.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_WIN      = 255;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    wgch_pkg::mode_t             op;
    logic [7:0]                  ch;
    logic                        in_reg;
    logic [wgch_pkg::BIN_W-1:0]  bin;
  } beat_t;

  typedef struct {
    logic                         kind;
    logic [wgch_pkg::BIN_W-1:0]   pct;
    logic [wgch_pkg::COUNT_W-1:0] count;
  } gc_result_t;

  // clock, reset and DUT ports
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = wgch_pkg::REG_WINDOW_SIZE;
  logic [wgch_pkg::WS_W-1:0]    cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   mode = wgch_pkg::MODE_BASE;
  logic [7:0]                   base = '0;
  logic                         in_region = 1'b0;
  logic [wgch_pkg::BIN_W-1:0]   bin_index = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         kind;
  logic [wgch_pkg::BIN_W-1:0]   gc_percent;
  logic [wgch_pkg::COUNT_W-1:0] bin_count;

  // stimulus and scoreboard
  beat_t      pending_beats[$];
  gc_result_t expected_results[$];
  beat_t      drv_beat;
  beat_t      seen_beat;
  gc_result_t want;
  logic       beat_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         queued_n = 0;
  int         accepted_n = 0;
  int         checked_n = 0;
  int         slide_n = 0;
  int         read_n = 0;
  int         fail_n = 0;

  // predictor state
  wgch_pkg::class_t             win_line [MAX_WIN];
  int                           win_gc;
  int                           win_at;
  int                           win_fill;
  logic [wgch_pkg::COUNT_W-1:0] pct_hist [wgch_pkg::HIST_BINS];
  logic [wgch_pkg::WS_W-1:0]    cur_ws;
  logic                         cur_mask;

  windowed_gc_percent_histogram_core #(
    .MAX_WINDOW(MAX_WIN)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .base      (base),
    .in_region (in_region),
    .bin_index (bin_index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .gc_percent(gc_percent),
    .bin_count (bin_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic wgch_pkg::class_t base_class(logic [7:0] ch);
    case (ch)
      "G", "g", "C", "c": return wgch_pkg::CLS_GC;
      "A", "a", "T", "t": return wgch_pkg::CLS_AT;
      default:            return wgch_pkg::CLS_OTHER;
    endcase
  endfunction

  task automatic win_clear();
    for (int i = 0; i < MAX_WIN; i++) win_line[i] = wgch_pkg::CLS_OTHER;
    win_gc   = 0;
    win_at   = 0;
    win_fill = 0;
  endtask

  task automatic hist_clear();
    for (int i = 0; i < wgch_pkg::HIST_BINS; i++) pct_hist[i] = '0;
  endtask

  // shift one class into the delay line and the running counts
  task automatic slide_in(wgch_pkg::class_t cls);
    for (int i = MAX_WIN - 1; i > 0; i--) win_line[i] = win_line[i-1];
    win_line[0] = cls;
    if (cls == wgch_pkg::CLS_GC) win_gc++;
    if (cls == wgch_pkg::CLS_AT) win_at++;
  endtask

  // queue a percentage beat and count it in the given bin
  task automatic push_percent(int pct, int hist_bin);
    gc_result_t r;
    r.kind  = wgch_pkg::KIND_PERCENT;
    r.pct   = wgch_pkg::BIN_W'(pct);
    r.count = '0;
    expected_results.push_back(r);
    pct_hist[hist_bin] = pct_hist[hist_bin] + 1;
  endtask

  task automatic gc_model_write(logic idx, logic [wgch_pkg::WS_W-1:0] val);
    if (idx == wgch_pkg::REG_WINDOW_SIZE) begin
      cur_ws = val;
      win_clear();
    end else begin
      cur_mask = val[0];
    end
  endtask

  task automatic gc_model_step(beat_t b);
    int               ws;
    int               n;
    int               pct;
    wgch_pkg::class_t cls;
    wgch_pkg::class_t old;
    gc_result_t       r;
    ws = (cur_ws == 0) ? 1 : int'(cur_ws);
    case (b.op)
      wgch_pkg::MODE_CLEAR: begin
        win_clear();
        hist_clear();
      end
      wgch_pkg::MODE_READ: begin
        r.kind  = wgch_pkg::KIND_COUNT;
        r.pct   = '0;
        r.count = (b.bin < wgch_pkg::HIST_BINS) ? pct_hist[b.bin] : '0;
        expected_results.push_back(r);
        read_n++;
      end
      wgch_pkg::MODE_PAD: begin
        push_percent(0, 0);
      end
      default: begin
        cls = base_class(b.ch);
        if (win_fill < ws) begin
          // window still filling: first half emits zero, rest is silent
          n = win_fill;
          slide_in(cls);
          win_fill++;
          if (n < ws / 2) push_percent(0, 0);
        end else begin
          old = win_line[ws-1];
          slide_in(cls);
          if (old == wgch_pkg::CLS_GC) win_gc--;
          if (old == wgch_pkg::CLS_AT) win_at--;
          if (win_gc + win_at < ws) pct = 0;
          else pct = (200 * win_gc + ws) / (2 * ws);
          if (pct > wgch_pkg::PCT_MAX) pct = wgch_pkg::PCT_MAX;
          push_percent(pct, (cur_mask && !b.in_reg) ? 0 : pct);
          slide_n++;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued beats at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (pending_beats.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        drv_beat   = pending_beats.pop_front();
        in_valid  <= 1'b1;
        mode      <= drv_beat.op;
        base      <= drv_beat.ch;
        in_region <= drv_beat.in_reg;
        bin_index <= drv_beat.bin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(1, 100) <= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results first, then predicts from the accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
      win_clear();
      hist_clear();
      cur_ws   = 8'd100;
      cur_mask = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_n++;
        if (expected_results.size() == 0) begin
          fail_n++;
          if (fail_n <= MAX_REPORTS)
            $display("%0t: unexpected beat kind %0d pct %0d count %0d", $realtime,
                     kind, gc_percent, bin_count);
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind || gc_percent !== want.pct || bin_count !== want.count) begin
            fail_n++;
            if (fail_n <= MAX_REPORTS)
              $display("%0t: mismatch: expected kind %0d pct %0d count %0d, got %0d %0d %0d",
                       $realtime, want.kind, want.pct, want.count,
                       kind, gc_percent, bin_count);
          end
        end
      end
      if (cfg_we) gc_model_write(cfg_index, cfg_data);
      beat_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen_beat.op     = wgch_pkg::mode_t'(mode);
        seen_beat.ch     = base;
        seen_beat.in_reg = in_region;
        seen_beat.bin    = bin_index;
        gc_model_step(seen_beat);
        accepted_n++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_beat(wgch_pkg::mode_t op, logic [7:0] ch, logic in_reg,
                            logic [wgch_pkg::BIN_W-1:0] bin);
    beat_t b;
    b.op     = op;
    b.ch     = ch;
    b.in_reg = in_reg;
    b.bin    = bin;
    pending_beats.push_back(b);
    queued_n++;
  endtask

  task automatic write_reg(logic idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wgch_pkg::WS_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // block goes idle: every beat taken, every result seen, silent work done
  task automatic drain();
    while (accepted_n != queued_n || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one configured stretch of random traffic, mostly bases
  task automatic run_random(int ws, int mask, int n, int base_pct, int clear_pct,
                            int other_pct);
    string                      gc_set;
    string                      at_set;
    int                         gc_bias;
    int                         r;
    logic [7:0]                 ch;
    logic [wgch_pkg::BIN_W-1:0] bin;
    gc_set  = "GCgc";
    at_set  = "ATat";
    gc_bias = $urandom_range(15, 85);
    write_reg(wgch_pkg::REG_WINDOW_SIZE, ws);
    write_reg(wgch_pkg::REG_REGION_MASK, mask);
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      bin = ($urandom_range(0, 7) == 0) ? wgch_pkg::BIN_W'($urandom_range(101, 127))
                                        : wgch_pkg::BIN_W'($urandom_range(0, 100));
      if (r < base_pct) begin
        if ($urandom_range(0, 99) < other_pct)
          ch = $urandom_range(0, 1) ? 8'($urandom) : ($urandom_range(0, 1) ? "N" : "n");
        else if ($urandom_range(0, 99) < gc_bias)
          ch = gc_set[$urandom_range(0, 3)];
        else
          ch = at_set[$urandom_range(0, 3)];
        queue_beat(wgch_pkg::MODE_BASE, ch, 1'($urandom), bin);
      end else if (r >= 100 - clear_pct) begin
        queue_beat(wgch_pkg::MODE_CLEAR, 8'($urandom), 1'($urandom), bin);
      end else if (r[0]) begin
        queue_beat(wgch_pkg::MODE_PAD, 8'($urandom), 1'($urandom), bin);
      end else begin
        queue_beat(wgch_pkg::MODE_READ, 8'($urandom), 1'($urandom), bin);
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct  = 17;
    recv_stall_pct = 75;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: window of four, mask at its reset value
    write_reg(wgch_pkg::REG_WINDOW_SIZE, 4);
    queue_beat(wgch_pkg::MODE_BASE, "G", 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "c", 1'b1, 7'd127);
    queue_beat(wgch_pkg::MODE_BASE, "a", 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "T", 1'b1, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "g", 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, 8'h00, 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, 8'hFF, 1'b1, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "C", 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "G", 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "c", 1'b1, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "G", 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_PAD, 8'hFF, 1'b1, 7'd127);
    queue_beat(wgch_pkg::MODE_READ, 8'h00, 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_READ, 8'h00, 1'b0, 7'd100);
    queue_beat(wgch_pkg::MODE_READ, 8'h00, 1'b0, 7'd50);
    queue_beat(wgch_pkg::MODE_READ, 8'hFF, 1'b1, 7'd127);
    queue_beat(wgch_pkg::MODE_READ, 8'h00, 1'b0, 7'd101);
    drain();

    // directed: out-of-region results go to bin zero, then restart
    write_reg(wgch_pkg::REG_REGION_MASK, 1);
    queue_beat(wgch_pkg::MODE_BASE, "A", 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "t", 1'b1, 7'd0);
    queue_beat(wgch_pkg::MODE_READ, 8'h00, 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_READ, 8'h00, 1'b0, 7'd50);
    queue_beat(wgch_pkg::MODE_CLEAR, 8'h00, 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_READ, 8'h00, 1'b0, 7'd0);
    queue_beat(wgch_pkg::MODE_BASE, "n", 1'b1, 7'd0);
    drain();

    // random traffic; window size zero acts as one
    run_random(1, 0, 90, 80, 2, 4);
    run_random(0, 1, 60, 80, 2, 4);
    run_random(2, 1, 100, 82, 2, 3);

    send_idle_pct  = 75;
    recv_stall_pct = 17;
    run_random(255, 0, 330, 97, 0, 0);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(7, 0, 90, 85, 2, 3);
    run_random(16, 1, 100, 85, 1, 2);

    $display("Covered %0d beats and %0d results: %0d sliding-window percentages, %0d bin reads.",
             accepted_n, checked_n, slide_n, read_n);
    $display("Window sizes 0 to 255 with region masking on and off; %0d failures.", fail_n);
    if (fail_n == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
